### src/mlrb_pkg.sv
`default_nettype none

package mlrb_pkg;

   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 24;
   localparam int unsigned LINE_WIDTH_W = 13;
   localparam int unsigned FIELD_W      = 5;
   localparam int unsigned GAIN_W       = 24;
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned PIXEL_W      = 8;
   localparam int unsigned COLUMN_W     = 12;
   localparam int unsigned AREA_W       = 2 * FIELD_W;

   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET   = 13'd4096;
   localparam logic [FIELD_W-1:0]      LOOK_LINES_RESET   = 5'd4;
   localparam logic [FIELD_W-1:0]      STEP_LINES_RESET   = 5'd4;
   localparam logic [FIELD_W-1:0]      STEP_SAMPLES_RESET = 5'd4;
   localparam logic [FIELD_W-1:0]      LOOK_SAMPLES_RESET = 5'd4;
   localparam logic [GAIN_W-1:0]       GAIN_RESET         = 24'd65536;

   localparam logic [FIELD_W-1:0] LINES_SINCE_MAX = 5'd31;

   localparam logic [63:0] Q_MAX         = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;
   localparam logic [56:0] ROUND_HALF    = 57'h80_0000;
   localparam int unsigned SCALE_SHIFT   = 24;
   localparam int unsigned FRAC_BITS     = 16;

   localparam int unsigned JOB_ACC_W = 56;
   localparam int unsigned JOB_COL_W = 16;
   localparam int unsigned JOB_ROW_W = 6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH   = 3'd0,
      CSR_LOOK_LINES   = 3'd1,
      CSR_STEP_LINES   = 3'd2,
      CSR_STEP_SAMPLES = 3'd3,
      CSR_LOOK_SAMPLES = 3'd4,
      CSR_GAIN         = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_WRITE,
      BK_READ,
      BK_ADD,
      BK_PREP,
      BK_DIV,
      BK_SQRT,
      BK_MUL,
      BK_OUT
   } bk_state_type;

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [COLUMN_W-1:0] out_column;
      logic                end_of_row;
      logic                drain_done;
   } rsp_type;

   typedef struct packed {
      logic [LINE_WIDTH_W-1:0] line_width;
      logic [FIELD_W-1:0]      look_lines;
      logic [FIELD_W-1:0]      step_lines;
      logic [FIELD_W-1:0]      step_samples;
      logic [FIELD_W-1:0]      look_samples;
      logic [GAIN_W-1:0]       gain;
   } cfg_type;

   typedef struct packed {
      logic                 write;
      logic                 emit;
      logic [JOB_ACC_W-1:0] acc;
      logic [JOB_COL_W-1:0] col;
      logic [JOB_ROW_W-1:0] head;
      logic [FIELD_W-1:0]   rows;
      logic                 eol;
      logic                 done;
   } job_type;

endpackage

`default_nettype wire

### src/mlrb_fifo.sv
`default_nettype none

module mlrb_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   output logic          full,
   input  wire item_type push_data,
   input  wire logic     pop,
   output logic          empty,
   output item_type      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   item_type        store_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (32'(count_ff) == DEPTH);
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### src/mlrb_front.sv
`default_nettype none

module mlrb_front #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LOOK_MAX    = 16,
   parameter int GROUP_MAX   = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mlrb_pkg::cfg_type cfg,
   input  wire logic              cfg_write,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire mlrb_pkg::req_type req_data,
   output logic                   job_push,
   input  wire logic              job_full,
   output mlrb_pkg::job_type      job_data
);

   localparam int SB   = (SAMPLE_BITS < mlrb_pkg::SAMPLE_W) ? SAMPLE_BITS : mlrb_pkg::SAMPLE_W;
   localparam int CW   = $clog2(MAX_WIDTH + 1);
   localparam int GW   = $clog2(MAX_WIDTH);
   localparam int FW   = $clog2(GROUP_MAX + 1);
   localparam int LW   = (LOOK_MAX > 1) ? $clog2(LOOK_MAX) : 1;
   localparam int AW   = 2 * SB + FW;
   localparam int KW   = mlrb_pkg::FIELD_W;
   localparam int DCW  = $clog2(CW + 1);

   logic [AW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]  sc_ff, sc_in;
   logic [GW-1:0]  gq_ff, gq_in;
   logic [FW-1:0]  gr_ff, gr_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [LW-1:0]  head_ff, head_in;
   logic [KW-1:0]  lb_ff, lb_in;
   logic [KW-1:0]  lso_ff, lso_in;
   logic [GW-1:0]  dcol_ff, dcol_in;
   logic [KW-1:0]  dwl_ff, dwl_in;
   logic           resync_ff, resync_in;
   logic           div_busy_ff, div_busy_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [CW-1:0]  div_num_ff, div_num_in;
   logic [FW-1:0]  div_rem_ff, div_rem_in;
   logic [CW-1:0]  div_quo_ff, div_quo_in;

   logic            accept;
   logic [SB-1:0]   x;
   logic [2*SB-1:0] sq;
   logic [AW-1:0]   acc_add;
   logic [FW-1:0]   fill_add;
   logic [CW-1:0]   sc_add;
   logic [FW-1:0]   gr_add;
   logic            eol;
   logic            close;
   logic            gwrap;
   logic            emit_line;
   logic [LW-1:0]   head_next;
   logic [31:0]     lso_look;
   logic [31:0]     w_raw;
   logic [KW-1:0]   drain_w;
   logic [KW-1:0]   dwl_cur;
   logic [GW-1:0]   dcol_cur;
   logic            drain_last;
   logic [KW-1:0]   dwl_after;
   logic            drain_done;
   logic [FW:0]     div_trial;
   logic            div_ge;
   logic [FW-1:0]   div_rem_next;
   logic            do_clear;

   assign req_full = job_full | div_busy_ff | resync_ff;
   assign accept   = req_push & ~req_full;

   assign x        = req_data.sample[SB-1:0];
   assign sq       = (2 * SB)'(x) * (2 * SB)'(x);
   assign acc_add  = acc_ff + AW'(sq);
   assign fill_add = fill_ff + 1'b1;
   assign sc_add   = sc_ff + 1'b1;
   assign gr_add   = gr_ff + 1'b1;
   assign eol      = 32'(sc_add) >= 32'(cfg.line_width);
   assign close    = (32'(fill_add) >= 32'(cfg.step_samples)) || eol;
   assign gwrap    = 32'(gr_add) >= 32'(cfg.step_samples);

   assign emit_line = (32'(lb_ff) + 32'd1 == 32'(cfg.look_lines)) ||
                      ((lb_ff >= cfg.look_lines) &&
                       (32'(lso_ff) + 32'd1 >= 32'(cfg.step_lines)));

   assign head_next = (32'(head_ff) == LOOK_MAX - 1) ? '0 : head_ff + 1'b1;

   always_comb begin
      lso_look = 32'(lso_ff) + 32'(cfg.look_lines);
      if (lb_ff < cfg.look_lines) begin
         w_raw = 32'(lb_ff);
      end else if (lso_look > 32'(cfg.step_lines)) begin
         w_raw = lso_look - 32'(cfg.step_lines);
      end else begin
         w_raw = 32'd0;
      end
      drain_w = (w_raw > 32'(lb_ff)) ? lb_ff : KW'(w_raw);
   end

   assign dwl_cur    = (dwl_ff == '0) ? drain_w : dwl_ff;
   assign dcol_cur   = (dwl_ff == '0) ? '0 : dcol_ff;
   assign drain_last = (32'(dcol_cur) + 32'd1) * 32'(cfg.step_samples) >=
                       32'(cfg.line_width);
   assign dwl_after  = (dwl_cur > cfg.step_lines) ? dwl_cur - cfg.step_lines : '0;
   assign drain_done = drain_last && (dwl_after == '0);

   assign div_trial    = {div_rem_ff, div_num_ff[CW-1]};
   assign div_ge       = 32'(div_trial) >= 32'(cfg.step_samples);
   assign div_rem_next = div_ge ? FW'(32'(div_trial) - 32'(cfg.step_samples))
                                : div_trial[FW-1:0];

   always_comb begin
      acc_in      = acc_ff;
      sc_in       = sc_ff;
      gq_in       = gq_ff;
      gr_in       = gr_ff;
      fill_in     = fill_ff;
      head_in     = head_ff;
      lb_in       = lb_ff;
      lso_in      = lso_ff;
      dcol_in     = dcol_ff;
      dwl_in      = dwl_ff;
      resync_in   = resync_ff;
      div_busy_in = div_busy_ff;
      div_cnt_in  = div_cnt_ff;
      div_num_in  = div_num_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      job_push    = 1'b0;
      job_data    = '0;
      do_clear    = 1'b0;

      // The group position is rebuilt from the sample column after any register write.
      if (cfg_write) begin
         resync_in   = 1'b1;
         div_busy_in = 1'b0;
      end else if (resync_ff) begin
         resync_in   = 1'b0;
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_num_in  = sc_ff;
         div_rem_in  = '0;
         div_quo_in  = '0;
      end else if (div_busy_ff) begin
         div_num_in = div_num_ff << 1;
         div_rem_in = div_rem_next;
         div_quo_in = {div_quo_ff[CW-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (32'(div_cnt_ff) == CW - 1) begin
            div_busy_in = 1'b0;
            gq_in       = GW'({div_quo_ff[CW-2:0], div_ge});
            gr_in       = div_rem_next;
         end
      end

      if (accept) begin
         if (req_data.command) begin
            if ((dwl_ff == '0) && (drain_w == '0)) begin
               do_clear = 1'b1;
            end else begin
               job_push       = 1'b1;
               job_data.write = 1'b0;
               job_data.emit  = 1'b1;
               job_data.col   = mlrb_pkg::JOB_COL_W'(dcol_cur);
               job_data.head  = mlrb_pkg::JOB_ROW_W'(head_ff);
               job_data.rows  = dwl_cur;
               job_data.eol   = drain_last;
               job_data.done  = drain_done;
               if (dwl_ff == '0) begin
                  acc_in  = '0;
                  sc_in   = '0;
                  gq_in   = '0;
                  gr_in   = '0;
                  fill_in = '0;
               end
               if (drain_last) begin
                  dcol_in = '0;
                  dwl_in  = dwl_after;
                  do_clear = drain_done;
               end else begin
                  dcol_in = dcol_cur + 1'b1;
                  dwl_in  = dwl_cur;
               end
            end
         end else if (dwl_ff == '0) begin
            acc_in  = acc_add;
            fill_in = fill_add;
            sc_in   = sc_add;
            if (gwrap) begin
               gq_in = gq_ff + 1'b1;
               gr_in = '0;
            end else begin
               gr_in = gr_add;
            end
            if (close) begin
               job_push       = 1'b1;
               job_data.write = 1'b1;
               job_data.emit  = emit_line;
               job_data.acc   = mlrb_pkg::JOB_ACC_W'(acc_add);
               job_data.col   = mlrb_pkg::JOB_COL_W'(gq_ff);
               job_data.head  = mlrb_pkg::JOB_ROW_W'(head_ff);
               job_data.rows  = cfg.look_lines - 1'b1;
               job_data.eol   = eol;
               job_data.done  = 1'b0;
               acc_in  = '0;
               fill_in = '0;
            end
            if (eol) begin
               sc_in   = '0;
               gq_in   = '0;
               gr_in   = '0;
               fill_in = '0;
               acc_in  = '0;
               if (emit_line) begin
                  lso_in = '0;
               end else if (lso_ff < mlrb_pkg::LINES_SINCE_MAX) begin
                  lso_in = lso_ff + 1'b1;
               end
               lb_in   = (lb_ff < cfg.look_lines) ? lb_ff + 1'b1 : cfg.look_lines;
               head_in = head_next;
            end
         end
      end

      if (do_clear) begin
         acc_in  = '0;
         sc_in   = '0;
         gq_in   = '0;
         gr_in   = '0;
         fill_in = '0;
         head_in = '0;
         lb_in   = '0;
         lso_in  = '0;
         dcol_in = '0;
         dwl_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         sc_ff       <= '0;
         gq_ff       <= '0;
         gr_ff       <= '0;
         fill_ff     <= '0;
         head_ff     <= '0;
         lb_ff       <= '0;
         lso_ff      <= '0;
         dcol_ff     <= '0;
         dwl_ff      <= '0;
         resync_ff   <= 1'b0;
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         acc_ff      <= acc_in;
         sc_ff       <= sc_in;
         gq_ff       <= gq_in;
         gr_ff       <= gr_in;
         fill_ff     <= fill_in;
         head_ff     <= head_in;
         lb_ff       <= lb_in;
         lso_ff      <= lso_in;
         dcol_ff     <= dcol_in;
         dwl_ff      <= dwl_in;
         resync_ff   <= resync_in;
         div_busy_ff <= div_busy_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
   end

endmodule

`default_nettype wire

### src/mlrb_back.sv
`default_nettype none

module mlrb_back #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LOOK_MAX    = 16,
   parameter int GROUP_MAX   = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mlrb_pkg::cfg_type cfg,
   input  wire logic              job_empty,
   output logic                   job_pop,
   input  wire mlrb_pkg::job_type job_data,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output mlrb_pkg::rsp_type      rsp_data
);

   localparam int SB  = (SAMPLE_BITS < mlrb_pkg::SAMPLE_W) ? SAMPLE_BITS : mlrb_pkg::SAMPLE_W;
   localparam int GW  = $clog2(MAX_WIDTH);
   localparam int FW  = $clog2(GROUP_MAX + 1);
   localparam int LW  = (LOOK_MAX > 1) ? $clog2(LOOK_MAX) : 1;
   localparam int AW  = 2 * SB + FW;
   localparam int SW  = AW + $clog2(LOOK_MAX);
   localparam int NW  = SW + mlrb_pkg::FRAC_BITS;
   localparam int XW  = (NW > 64) ? NW : 64;
   localparam int DCW = $clog2(NW + 1);
   localparam int RW  = mlrb_pkg::AREA_W;
   localparam int KW  = mlrb_pkg::FIELD_W;

   logic [AW-1:0] ring_mem [LOOK_MAX][MAX_WIDTH];

   mlrb_pkg::bk_state_type state_ff, state_in;
   mlrb_pkg::job_type      job_ff, job_in;
   logic [SW-1:0]          sum_ff, sum_in;
   logic [LW-1:0]          row_ff, row_in;
   logic [KW-1:0]          left_ff, left_in;
   logic [AW-1:0]          rd_data_ff;
   logic [NW-1:0]          num_ff, num_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [NW-1:0]          quo_ff, quo_in;
   logic [DCW-1:0]         cnt_ff, cnt_in;
   logic [63:0]            x_ff, x_in;
   logic [63:0]            r_ff, r_in;
   logic [63:0]            bit_ff, bit_in;
   logic [55:0]            prod_ff, prod_in;

   logic [LW-1:0] row_dec;
   logic [GW-1:0] col;
   logic [RW-1:0] area;
   logic [RW:0]   trial;
   logic          ge;
   logic [NW-1:0] quo_next;
   logic          q_sat;
   logic [63:0]   root_sum;
   logic [56:0]   rounded;
   logic [32:0]   pix_wide;
   logic          mem_we;

   assign row_dec  = (row_ff == '0) ? LW'(LOOK_MAX - 1) : row_ff - 1'b1;
   assign col      = job_ff.col[GW-1:0];
   assign area     = RW'(cfg.look_lines) * RW'(cfg.look_samples);
   assign trial    = {rem_ff, num_ff[NW-1]};
   assign ge       = trial >= {1'b0, area};
   assign quo_next = {quo_ff[NW-2:0], ge};
   assign q_sat    = XW'(quo_next) > XW'(mlrb_pkg::Q_MAX);
   assign root_sum = r_ff + bit_ff;
   assign rounded  = 57'(prod_ff) + mlrb_pkg::ROUND_HALF;
   assign pix_wide = rounded[56:mlrb_pkg::SCALE_SHIFT];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlrb_pkg::BK_IDLE: begin
            if (!job_empty) begin
               if (job_data.write) begin
                  state_in = mlrb_pkg::BK_WRITE;
               end else if (job_data.rows == '0) begin
                  state_in = mlrb_pkg::BK_PREP;
               end else begin
                  state_in = mlrb_pkg::BK_READ;
               end
            end
         end
         mlrb_pkg::BK_WRITE: begin
            if (!job_ff.emit) begin
               state_in = mlrb_pkg::BK_IDLE;
            end else if (left_ff == '0) begin
               state_in = mlrb_pkg::BK_PREP;
            end else begin
               state_in = mlrb_pkg::BK_READ;
            end
         end
         mlrb_pkg::BK_READ: begin
            state_in = mlrb_pkg::BK_ADD;
         end
         mlrb_pkg::BK_ADD: begin
            state_in = (left_ff == KW'(1)) ? mlrb_pkg::BK_PREP : mlrb_pkg::BK_READ;
         end
         mlrb_pkg::BK_PREP: begin
            state_in = mlrb_pkg::BK_DIV;
         end
         mlrb_pkg::BK_DIV: begin
            if (32'(cnt_ff) == NW - 1) begin
               state_in = mlrb_pkg::BK_SQRT;
            end
         end
         mlrb_pkg::BK_SQRT: begin
            if (bit_ff == 64'd1) begin
               state_in = mlrb_pkg::BK_MUL;
            end
         end
         mlrb_pkg::BK_MUL: begin
            state_in = mlrb_pkg::BK_OUT;
         end
         mlrb_pkg::BK_OUT: begin
            if (!rsp_full) begin
               state_in = mlrb_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mlrb_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      job_pop             = (state_ff == mlrb_pkg::BK_IDLE) && !job_empty;
      mem_we              = (state_ff == mlrb_pkg::BK_WRITE);
      rsp_push            = (state_ff == mlrb_pkg::BK_OUT) && !rsp_full;
      rsp_data.pixel      = (|pix_wide[32:8]) ? 8'hFF : pix_wide[7:0];
      rsp_data.out_column = job_ff.col[mlrb_pkg::COLUMN_W-1:0];
      rsp_data.end_of_row = job_ff.eol;
      rsp_data.drain_done = job_ff.done;
   end

   always_comb begin
      job_in  = job_ff;
      sum_in  = sum_ff;
      row_in  = row_ff;
      left_in = left_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      prod_in = prod_ff;
      case (state_ff)
         mlrb_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_in  = job_data;
               sum_in  = SW'(job_data.acc[AW-1:0]);
               row_in  = job_data.head[LW-1:0];
               left_in = job_data.rows;
            end
         end
         mlrb_pkg::BK_READ: begin
            row_in = row_dec;
         end
         mlrb_pkg::BK_ADD: begin
            sum_in  = sum_ff + SW'(rd_data_ff);
            left_in = left_ff - 1'b1;
         end
         mlrb_pkg::BK_PREP: begin
            num_in = {sum_ff, {mlrb_pkg::FRAC_BITS{1'b0}}};
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
         end
         mlrb_pkg::BK_DIV: begin
            num_in = num_ff << 1;
            rem_in = ge ? RW'(trial - {1'b0, area}) : trial[RW-1:0];
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            x_in   = q_sat ? mlrb_pkg::Q_MAX : 64'(quo_next);
            r_in   = '0;
            bit_in = mlrb_pkg::SQRT_BIT_INIT;
         end
         mlrb_pkg::BK_SQRT: begin
            if (x_ff >= root_sum) begin
               x_in = x_ff - root_sum;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         mlrb_pkg::BK_MUL: begin
            prod_in = 56'(r_ff[31:0]) * 56'(cfg.gain);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlrb_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      sum_ff  <= sum_in;
      row_ff  <= row_in;
      left_ff <= left_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[job_ff.head[LW-1:0]][col] <= job_ff.acc[AW-1:0];
      end
      rd_data_ff <= ring_mem[row_dec][col];
   end

endmodule

`default_nettype wire

### src/multilook_rms_to_byte_core.sv
// A sample word is taken whenever the job queue has room and no group realignment is under way;
// words that close a column group queue one job for the back end. A stored-only group takes
// the back end through its write state only; the time a pixel takes is set by the ring walk,
// the one-bit-per-cycle divider and the 32-step integer root.
// After a register write the sample path pauses while the group count is realigned.
// Reset clears all control state and restores register defaults; the ring is not cleared.
`default_nettype none

module multilook_rms_to_byte_core #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LOOK_MAX    = 16,
   parameter int GROUP_MAX   = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire mlrb_pkg::req_type                   req_data,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output mlrb_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [mlrb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mlrb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int KW = mlrb_pkg::FIELD_W;

   logic [mlrb_pkg::LINE_WIDTH_W-1:0] line_width_ff, line_width_in;
   logic [KW-1:0]                     look_lines_ff, look_lines_in;
   logic [KW-1:0]                     step_lines_ff, step_lines_in;
   logic [KW-1:0]                     step_samples_ff, step_samples_in;
   logic [KW-1:0]                     look_samples_ff, look_samples_in;
   logic [mlrb_pkg::GAIN_W-1:0]       gain_ff, gain_in;

   mlrb_pkg::cfg_type cfg;
   logic [KW-1:0]     eff_look;

   logic              job_push;
   logic              job_full;
   mlrb_pkg::job_type job_in_data;
   logic              job_pop;
   logic              job_empty;
   mlrb_pkg::job_type job_out_data;
   logic              rsp_push;
   logic              rsp_full;
   mlrb_pkg::rsp_type rsp_in_data;

   always_comb begin
      line_width_in   = line_width_ff;
      look_lines_in   = look_lines_ff;
      step_lines_in   = step_lines_ff;
      step_samples_in = step_samples_ff;
      look_samples_in = look_samples_ff;
      gain_in         = gain_ff;
      if (csr_we) begin
         case (csr_index)
            mlrb_pkg::CSR_LINE_WIDTH:   line_width_in   = csr_wdata[mlrb_pkg::LINE_WIDTH_W-1:0];
            mlrb_pkg::CSR_LOOK_LINES:   look_lines_in   = csr_wdata[KW-1:0];
            mlrb_pkg::CSR_STEP_LINES:   step_lines_in   = csr_wdata[KW-1:0];
            mlrb_pkg::CSR_STEP_SAMPLES: step_samples_in = csr_wdata[KW-1:0];
            mlrb_pkg::CSR_LOOK_SAMPLES: look_samples_in = csr_wdata[KW-1:0];
            mlrb_pkg::CSR_GAIN:         gain_in         = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= mlrb_pkg::LINE_WIDTH_RESET;
         look_lines_ff   <= mlrb_pkg::LOOK_LINES_RESET;
         step_lines_ff   <= mlrb_pkg::STEP_LINES_RESET;
         step_samples_ff <= mlrb_pkg::STEP_SAMPLES_RESET;
         look_samples_ff <= mlrb_pkg::LOOK_SAMPLES_RESET;
         gain_ff         <= mlrb_pkg::GAIN_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         look_lines_ff   <= look_lines_in;
         step_lines_ff   <= step_lines_in;
         step_samples_ff <= step_samples_in;
         look_samples_ff <= look_samples_in;
         gain_ff         <= gain_in;
      end
   end

   // Registers hold what was written; the datapath sees the clamped values.
   always_comb begin
      if (line_width_ff == '0) begin
         cfg.line_width = mlrb_pkg::LINE_WIDTH_W'(1);
      end else if (32'(line_width_ff) > MAX_WIDTH) begin
         cfg.line_width = mlrb_pkg::LINE_WIDTH_W'(MAX_WIDTH);
      end else begin
         cfg.line_width = line_width_ff;
      end

      if (look_lines_ff == '0) begin
         eff_look = KW'(1);
      end else if (32'(look_lines_ff) > LOOK_MAX) begin
         eff_look = KW'(LOOK_MAX);
      end else begin
         eff_look = look_lines_ff;
      end
      cfg.look_lines = eff_look;

      if (step_lines_ff == '0) begin
         cfg.step_lines = KW'(1);
      end else if (step_lines_ff > eff_look) begin
         cfg.step_lines = eff_look;
      end else begin
         cfg.step_lines = step_lines_ff;
      end

      if (step_samples_ff == '0) begin
         cfg.step_samples = KW'(1);
      end else if (32'(step_samples_ff) > GROUP_MAX) begin
         cfg.step_samples = KW'(GROUP_MAX);
      end else begin
         cfg.step_samples = step_samples_ff;
      end

      cfg.look_samples = (look_samples_ff == '0) ? KW'(1) : look_samples_ff;
      cfg.gain         = gain_ff;
   end

   mlrb_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .LOOK_MAX    (LOOK_MAX),
      .GROUP_MAX   (GROUP_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_write (csr_we),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_push  (job_push),
      .job_full  (job_full),
      .job_data  (job_in_data)
   );

   mlrb_fifo #(
      .item_type (mlrb_pkg::job_type),
      .DEPTH     (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_in_data),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_out_data)
   );

   mlrb_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .LOOK_MAX    (LOOK_MAX),
      .GROUP_MAX   (GROUP_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_data  (job_out_data),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data)
   );

   mlrb_fifo #(
      .item_type (mlrb_pkg::rsp_type),
      .DEPTH     (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .full      (rsp_full),
      .push_data (rsp_in_data),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

`default_nettype wire
